[design/pse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants
// Token codes, status codes, item structs and controller/datapath commands.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DefStackDepth = 64;

    localparam logic [7:0] TOK_NOP        = 8'd0;
    localparam logic [7:0] TOK_ADD        = 8'd1;
    localparam logic [7:0] TOK_SUB        = 8'd2;
    localparam logic [7:0] TOK_MUL        = 8'd3;
    localparam logic [7:0] TOK_DIV        = 8'd4;
    localparam logic [7:0] TOK_AND        = 8'd5;
    localparam logic [7:0] TOK_OR         = 8'd6;
    localparam logic [7:0] TOK_XOR        = 8'd7;
    localparam logic [7:0] TOK_NEG        = 8'd8;
    localparam logic [7:0] TOK_NOT        = 8'd9;
    localparam logic [7:0] TOK_STORE      = 8'd10;
    localparam logic [7:0] TOK_STORE_DISP = 8'd11;
    localparam logic [7:0] TOK_SYMBOL     = 8'd14;
    localparam logic [7:0] TOK_SECTION    = 8'd15;
    localparam logic [7:0] TOK_CONST      = 8'd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIVZERO   = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_LEFTOVER  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_UNDERFLOW = 3'd5;
    localparam logic [2:0] ST_NOSYM     = 3'd6;
    localparam logic [2:0] ST_BADTOKEN  = 3'd7;

    typedef struct packed {
        logic [7:0]  operation;
        logic [15:0] operand_value;
        logic        symbol_missing;
        logic [15:0] location_word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] result_word;
        logic [2:0]  status;
    } out_item_t;

    // Arithmetic unit selection
    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NEG, ALU_NOT
    } alu_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_tok;    // capture input item
        logic    rd_top;      // read entry count-1 into b
        logic    rd_next;     // read entry count-2 into a
        logic    wr_push;     // write push value at count, count++
        logic    wr_bin;      // write result at count-2, count--
        logic    wr_un;       // write result at count-1
        logic    alu_go;      // register simple alu result
        alu_op_t alu_op;
        logic    md_start;    // start multiply/divide unit
        logic    md_div;
        logic    set_err;
        logic [2:0] err;
        logic    emit;        // emit result from store
        logic    emit_bad;
        logic    clear;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [7:0] op;
        logic       missing;
        logic       cnt_zero;
        logic       cnt_lt2;
        logic       full;
        logic       b_zero;
        logic       md_done;
    } sts_t;

endpackage

[design/postfix_stack_evaluator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core: postfix relocation expression evaluator
// Controller plus datapath with a RAM value stack and iterative mul/div.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and pulse start while busy is low; the item is taken at
//   that edge and busy rises on the next cycle. Multiply and divide run
//   in the shared one-bit-per-cycle unit. The stack RAM has one port and a
//   registered read, which sets the read/compute/write sequence length.
//   Store, store-displaced and bad tokens raise out_valid for exactly one
//   cycle with out_item, before busy falls; the receiver cannot stall,
//   so results are taken in that cycle. Other tokens give no result.
//   Errors are sticky until a store or bad token clears the expression.
//   Reset empties the stack and clears the error; the stack RAM needs no
//   clearing pass since only entries below the count are read.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core #(
    parameter int STACK_DEPTH = pse_pkg::DefStackDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pse_pkg::in_item_t  in_item,
    output logic               out_valid,
    output pse_pkg::out_item_t out_item
);
    pse_pkg::ctl_t ctl;
    pse_pkg::sts_t sts;

    pse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    pse_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .ctl       (ctl),
        .sts       (sts),
        .out_item  (out_item),
        .out_valid (out_valid)
    );
endmodule

[design/pse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ram: generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read at one address
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

[design/pse_muldiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_muldiv: iterative multiply and signed divide
// Shift-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module pse_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_div,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] result
);
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        div_reg;
    logic        neg_reg;
    logic [31:0] acc_reg;   // product or remainder
    logic [31:0] q_reg;     // multiplier or quotient
    logic [31:0] m_reg;     // multiplicand or divisor magnitude
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign mag_a  = a[31] ? (32'd0 - a) : a;
    assign mag_b  = b[31] ? (32'd0 - b) : b;
    assign rem_sh = {acc_reg[30:0], q_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, m_reg};

    // Step one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                div_reg  <= is_div;
                neg_reg  <= a[31] ^ b[31];
                acc_reg  <= '0;
                q_reg    <= is_div ? mag_a : b;
                m_reg    <= is_div ? mag_b : a;
            end
            else if (busy_reg)
            begin
                if (div_reg)
                begin
                    acc_reg <= trial[32] ? rem_sh : trial[31:0];
                    q_reg   <= {q_reg[30:0], ~trial[32]};
                end
                else
                begin
                    acc_reg <= (acc_reg << 1) + (q_reg[31] ? m_reg : 32'd0);
                    q_reg   <= q_reg << 1;
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // Apply quotient sign
    assign result = !div_reg ? acc_reg : (neg_reg ? (32'd0 - q_reg) : q_reg);
endmodule

[design/pse_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_datapath: stack memory, operand registers and arithmetic
// Executes controller commands; reports stack and token status.
// ----------------------------------------------------------------------------
module pse_datapath #(
    parameter int STACK_DEPTH = pse_pkg::DefStackDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pse_pkg::in_item_t  in_item,
    input  pse_pkg::ctl_t      ctl,
    output pse_pkg::sts_t      sts,
    output pse_pkg::out_item_t out_item,
    output logic               out_valid
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    pse_pkg::in_item_t tok_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]    err_reg;
    logic [31:0]   a_reg;
    logic [31:0]   b_reg;
    logic [31:0]   r_reg;
    logic          a_pend_reg;
    logic          b_pend_reg;
    logic [31:0]   rdata;
    logic [AW-1:0] addr;
    logic          we;
    logic [31:0]   wdata;
    logic [31:0]   md_res;
    logic [31:0]   push_val;
    logic [31:0]   disp;
    logic [2:0]    st;

    // Memory address and write data
    always_comb
    begin
        we    = ctl.wr_push | ctl.wr_bin | ctl.wr_un;
        wdata = ctl.wr_push ? push_val : r_reg;
        if (ctl.wr_push)
            addr = cnt_reg[AW-1:0];
        else if (ctl.rd_next || ctl.wr_bin)
            addr = AW'(cnt_reg - CW'(2));
        else
            addr = AW'(cnt_reg - CW'(1));
    end

    assign push_val = (tok_reg.operation == pse_pkg::TOK_SECTION ||
                       (tok_reg.operation == pse_pkg::TOK_SYMBOL &&
                        tok_reg.symbol_missing)) ? 32'd0
                      : {16'd0, tok_reg.operand_value};

    pse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    pse_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.md_start),
        .is_div (ctl.md_div),
        .a      (a_reg),
        .b      (b_reg),
        .done   (sts.md_done),
        .result (md_res)
    );

    // Hold count, error, operands and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            err_reg    <= pse_pkg::ST_OK;
            a_pend_reg <= 1'b0;
            b_pend_reg <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            out_valid  <= 1'b0;
            a_pend_reg <= ctl.rd_next;
            b_pend_reg <= ctl.rd_top;
            if (a_pend_reg)
                a_reg <= rdata;
            if (b_pend_reg)
                b_reg <= rdata;
            if (ctl.load_tok)
                tok_reg <= in_item;
            if (ctl.alu_go)
            begin
                case (ctl.alu_op)
                    pse_pkg::ALU_ADD: r_reg <= a_reg + b_reg;
                    pse_pkg::ALU_SUB: r_reg <= a_reg - b_reg;
                    pse_pkg::ALU_AND: r_reg <= a_reg & b_reg;
                    pse_pkg::ALU_OR:  r_reg <= a_reg | b_reg;
                    pse_pkg::ALU_XOR: r_reg <= a_reg ^ b_reg;
                    pse_pkg::ALU_NEG: r_reg <= 32'd0 - b_reg;
                    pse_pkg::ALU_NOT: r_reg <= ~b_reg;
                    default:          r_reg <= b_reg;
                endcase
            end
            if (sts.md_done)
                r_reg <= (ctl.md_div && b_reg == 32'd0) ? 32'd0 : md_res;
            if (ctl.set_err && err_reg == pse_pkg::ST_OK)
                err_reg <= ctl.err;
            if (ctl.wr_push)
                cnt_reg <= cnt_reg + CW'(1);
            if (ctl.wr_bin)
                cnt_reg <= cnt_reg - CW'(1);
            if (ctl.emit || ctl.emit_bad)
            begin
                out_valid <= 1'b1;
                out_item.result_word <= ctl.emit_bad ? 16'd0 : disp[15:0];
                out_item.status      <= ctl.emit_bad ? pse_pkg::ST_BADTOKEN : st;
            end
            if (ctl.clear)
            begin
                cnt_reg <= '0;
                err_reg <= pse_pkg::ST_OK;
            end
        end
    end

    // Store value and status
    always_comb
    begin
        disp = 32'd0;
        st   = err_reg;
        if (cnt_reg == '0)
        begin
            if (err_reg == pse_pkg::ST_OK)
                st = pse_pkg::ST_EMPTY;
        end
        else
        begin
            disp = b_reg;
            if (tok_reg.operation == pse_pkg::TOK_STORE_DISP)
                disp = b_reg - {16'd0, tok_reg.location_word};
            if (cnt_reg > CW'(1) && err_reg == pse_pkg::ST_OK)
                st = pse_pkg::ST_LEFTOVER;
        end
    end

    assign sts.op       = tok_reg.operation;
    assign sts.missing  = tok_reg.symbol_missing;
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.cnt_lt2  = (cnt_reg < CW'(2));
    assign sts.full     = (cnt_reg >= CW'(STACK_DEPTH));
    assign sts.b_zero   = (b_reg == 32'd0);
endmodule

[design/pse_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ctrl: token sequencer
// Decodes each item and steps the datapath through read, compute, write.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pse_pkg::sts_t sts,
    output pse_pkg::ctl_t ctl
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_NEXT, S_WAIT_A, S_WAIT_B, S_EXEC,
        S_MD, S_WR_BIN, S_WR_UN, S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   bin;
    logic   un;
    logic   st_op;
    logic   push;

    assign bin   = sts.op >= pse_pkg::TOK_ADD && sts.op <= pse_pkg::TOK_XOR;
    assign un    = sts.op == pse_pkg::TOK_NEG || sts.op == pse_pkg::TOK_NOT;
    assign st_op = sts.op == pse_pkg::TOK_STORE || sts.op == pse_pkg::TOK_STORE_DISP;
    assign push  = sts.op == pse_pkg::TOK_SYMBOL || sts.op == pse_pkg::TOK_SECTION
                   || sts.op == pse_pkg::TOK_CONST;

    // Next state and commands
    always_comb
    begin
        ctl        = '0;
        ctl.alu_op = pse_pkg::ALU_ADD;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load_tok = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                if (bin)
                begin
                    if (sts.cnt_lt2)
                    begin
                        ctl.set_err = 1'b1;
                        ctl.err     = pse_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.rd_top = 1'b1;
                        state_next = S_RD_NEXT;
                    end
                end
                else if (un || st_op)
                begin
                    if (un && sts.cnt_zero)
                    begin
                        ctl.set_err = 1'b1;
                        ctl.err     = pse_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.rd_top = !sts.cnt_zero;
                        state_next = S_WAIT_B;
                    end
                end
                else if (push)
                begin
                    if (sts.op == pse_pkg::TOK_SYMBOL && sts.missing)
                    begin
                        ctl.set_err = 1'b1;
                        ctl.err     = pse_pkg::ST_NOSYM;
                    end
                    else if (sts.full)
                    begin
                        ctl.set_err = 1'b1;
                        ctl.err     = pse_pkg::ST_OVERFLOW;
                    end
                    // Missing symbol still pushes zero; a full stack blocks the push
                    if (!sts.full)
                        ctl.wr_push = 1'b1;
                    else if (sts.op == pse_pkg::TOK_SYMBOL && sts.missing)
                        ctl.err = pse_pkg::ST_NOSYM;
                end
                else if (sts.op != pse_pkg::TOK_NOP)
                begin
                    ctl.emit_bad = 1'b1;
                    ctl.clear    = 1'b1;
                end
            end
            S_RD_NEXT:
            begin
                ctl.rd_next = 1'b1;
                state_next  = S_WAIT_A;
            end
            S_WAIT_A:
            begin
                state_next = S_EXEC;
            end
            S_WAIT_B:
            begin
                if (st_op)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st_op)
                begin
                    ctl.emit   = 1'b1;
                    ctl.clear  = 1'b1;
                    state_next = S_DONE;
                end
                else if (un)
                begin
                    ctl.alu_go = 1'b1;
                    ctl.alu_op = (sts.op == pse_pkg::TOK_NEG) ? pse_pkg::ALU_NEG
                                                              : pse_pkg::ALU_NOT;
                    state_next = S_WR_UN;
                end
                else if (sts.op == pse_pkg::TOK_MUL || sts.op == pse_pkg::TOK_DIV)
                begin
                    ctl.md_start = 1'b1;
                    ctl.md_div   = sts.op == pse_pkg::TOK_DIV;
                    if (sts.op == pse_pkg::TOK_DIV && sts.b_zero)
                    begin
                        ctl.set_err = 1'b1;
                        ctl.err     = pse_pkg::ST_DIVZERO;
                    end
                    state_next = S_MD;
                end
                else
                begin
                    ctl.alu_go = 1'b1;
                    case (sts.op)
                        pse_pkg::TOK_SUB: ctl.alu_op = pse_pkg::ALU_SUB;
                        pse_pkg::TOK_AND: ctl.alu_op = pse_pkg::ALU_AND;
                        pse_pkg::TOK_OR:  ctl.alu_op = pse_pkg::ALU_OR;
                        pse_pkg::TOK_XOR: ctl.alu_op = pse_pkg::ALU_XOR;
                        default:          ctl.alu_op = pse_pkg::ALU_ADD;
                    endcase
                    state_next = S_WR_BIN;
                end
            end
            S_MD:
            begin
                ctl.md_div = sts.op == pse_pkg::TOK_DIV;
                if (sts.md_done)
                    state_next = S_WR_BIN;
            end
            S_WR_BIN:
            begin
                ctl.wr_bin = 1'b1;
                state_next = S_DONE;
            end
            S_WR_UN:
            begin
                ctl.wr_un  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy      <= state_next != S_IDLE;
        end
    end
endmodule

[design/pse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_checker: port-level checks
// Watches handshake and result behavior at the top-level ports.
// ----------------------------------------------------------------------------
module pse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               out_valid,
    input pse_pkg::out_item_t out_item
);
    // Accepted item makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after accept");

    // Results appear only while busy
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result outside item");

    // Single-cycle strobe
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("result strobe too long");

    // Bad token carries a zero word
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == pse_pkg::ST_BADTOKEN |->
        out_item.result_word == 16'd0)
        else $error("bad token word nonzero");
endmodule

bind postfix_stack_evaluator_core pse_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
);
